// ----- rtl/core/swm_pkg.sv -----
package swm_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int WIN_LEN_W = 5;

  // defaults
  localparam int MAX_WINDOW_DEF = 16;
  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST = WIN_LEN_W'(3);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_FIN  = 3'b100
  } swm_state_t;

  // sequencer status towards the top level
  typedef struct packed {
    logic idle;
    logic reading;
    logic finishing;
    logic rd_vld;
  } swm_status_t;

endpackage

// ----- rtl/core/swm_ring.sv -----
module swm_ring #(
  parameter int MAX_WINDOW = 16,
  parameter int AW = 4
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] wdata,
  input  logic                                re,
  input  logic [AW-1:0]                       raddr,
  output logic signed [swm_pkg::SAMPLE_W-1:0] rdata
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/swm_ctrl.sv -----
module swm_ctrl #(
  parameter int MAX_WINDOW = 16,
  parameter int AW = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [swm_pkg::WIN_LEN_W-1:0]        window_len,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 last,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  window_max,
  output logic                                 final_res,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 mem_we,
  output logic [AW-1:0]                        mem_waddr,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  mem_wdata,
  output logic                                 mem_re,
  output logic [AW-1:0]                        mem_raddr,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  mem_rdata,
  output swm_pkg::swm_status_t                 status
);
  import swm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int LW = (CW > WIN_LEN_W) ? CW : WIN_LEN_W;
  localparam logic [AW-1:0] LAST_POS = AW'(MAX_WINDOW - 1);
  localparam logic [CW-1:0] SEEN_MAX = CW'(MAX_WINDOW);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_WINDOW);

  swm_state_t state;
  logic [AW-1:0] wr_pos;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] seen;
  logic [CW-1:0] seen_next;
  logic [LW-1:0] rem;
  logic [LW-1:0] wl_ext;
  logic [LW-1:0] len_eff;
  logic [LW-1:0] seen_ext;
  logic [LW-1:0] span;
  logic rd_vld;
  logic signed [SAMPLE_W-1:0] best;
  logic fin;
  logic accept;
  logic need_res;
  logic out_load;

  function automatic logic [AW-1:0] pos_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_POS : p - AW'(1);
  endfunction

  assign accept = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);

  // result register takes a new result when empty or being emptied
  assign out_load = (state == ST_FIN) && (!out_valid || out_ready);

  // effective window length and span of this request
  always_comb begin
    wl_ext = LW'(window_len);
    if (wl_ext == '0) begin
      len_eff = LW'(1);
    end else if (wl_ext > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = wl_ext;
    end
    seen_next = (seen == SEEN_MAX) ? seen : seen + CW'(1);
    seen_ext = LW'(seen_next);
    span = (seen_ext < len_eff) ? seen_ext : len_eff;
    need_res = last || (seen_ext >= len_eff);
  end

  // ring store access
  assign mem_we = accept;
  assign mem_waddr = wr_pos;
  assign mem_wdata = sample;
  assign mem_re = (state == ST_READ) && (rem != '0);
  assign mem_raddr = rd_ptr;

  // sequencer: write, walk back through the window, then hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wr_pos <= '0;
      seen <= '0;
      rem <= '0;
      rd_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= mem_re;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (last) begin
              wr_pos <= '0;
              seen <= '0;
            end else begin
              wr_pos <= (wr_pos == LAST_POS) ? '0 : wr_pos + AW'(1);
              seen <= seen_next;
            end
            rd_ptr <= pos_dec(wr_pos);
            rem <= span - LW'(1);
            best <= sample;
            fin <= last;
            if (need_res) begin
              state <= (span == LW'(1)) ? ST_FIN : ST_READ;
            end
          end
        end
        ST_READ: begin
          if (rem != '0) begin
            rd_ptr <= pos_dec(rd_ptr);
            rem <= rem - LW'(1);
          end
          if (rd_vld && (mem_rdata > best)) begin
            best <= mem_rdata;
          end
          if ((rem == '0) && !rd_vld) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            window_max <= best;
            final_res <= fin;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign status.idle = (state == ST_IDLE);
  assign status.reading = (state == ST_READ);
  assign status.finishing = (state == ST_FIN);
  assign status.rd_vld = rd_vld;

endmodule

// ----- rtl/core/sliding_window_maximum.sv -----
// Channel   Handshake            Payload
// input     in_valid / in_ready  sample[15:0] signed, last
// output    out_valid/ out_ready window_max[15:0] signed, final_res
// config    cfg_we               cfg_data[4:0] (window length)
//
// A request that gives no result leaves the block idle for the next request. A
// request with a result goes straight to the finishing step when the span is
// one sample (span = samples in the window); otherwise the single read port of
// the ring store gives one earlier sample per cycle to the running maximum, the
// read pipe empties and then the result register is loaded.
// Reset is synchronous; the ring store is not cleared and needs no sweep.
// The result register lets the next request in while a result waits; a stall
// on the output only holds the block once a second result is ready.
module sliding_window_maximum #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [swm_pkg::WIN_LEN_W-1:0]        cfg_data,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 last,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  window_max,
  output logic                                 final_res,
  output logic                                 out_valid,
  input  logic                                 out_ready
);
  import swm_pkg::*;

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [WIN_LEN_W-1:0] window_len;
  logic mem_we;
  logic mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;
  logic signed [SAMPLE_W-1:0] mem_rdata;
  swm_status_t status;

  // window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WIN_LEN_RST;
    end else if (cfg_we) begin
      window_len <= cfg_data;
    end
  end

  swm_ring #(
    .MAX_WINDOW(MAX_WINDOW),
    .AW(AW)
  ) u_ring (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  swm_ctrl #(
    .MAX_WINDOW(MAX_WINDOW),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .window_len(window_len),
    .sample(sample),
    .last(last),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .window_max(window_max),
    .final_res(final_res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .status(status)
  );

`ifndef SYNTHESIS
  // no new request while the window walk is in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> status.idle)
    else $error("request taken while sequencer busy");

  // read data only follows a read issued in the walk
  a_rd_after_read: assert property (@(posedge clk) disable iff (rst)
    status.rd_vld |-> $past(status.reading))
    else $error("read data without a read");

  // a result appears only out of the finishing step
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(status.finishing))
    else $error("result loaded outside finishing step");
`endif

endmodule
